### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the perpendicular pair design
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold on every clock edge outside reset
`define PFV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pfv assertion failed");
// condition must never be seen outside reset
`define PFV_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pfv forbidden condition seen");
`else
`define PFV_ASSERT(lbl, prop)
`define PFV_NEVER(lbl, expr)
`endif

`endif

### design/pfv_pkg.sv
// ----------------------------------------------------------------------------
// pfv_pkg
// types, widths and constants of the perpendicular pair pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package pfv_pkg;

    localparam int DATA_W    = 32;                 // Q16.16 component
    localparam int FRAC_W    = 16;
    localparam int CFG_W     = 17;
    localparam logic [CFG_W-1:0] MIN_LENGTH_RESET = 17'd1;

    localparam int SQ_W      = 2 * DATA_W;         // squared length, Q32.32
    localparam int LEN_W     = SQ_W / 2;           // length, Q16.16
    localparam int ROOT_IN_W = LEN_W + FRAC_W;     // length shifted for sqrt
    localparam int ROOT_W    = ROOT_IN_W / 2;      // sqrt of length
    localparam int PROD_A_W  = LEN_W + ROOT_W;     // |w| * root
    localparam int A_W       = ROOT_W + 1;         // |a_i| <= root
    localparam int PROD_B_W  = DATA_W + A_W;       // v_i * a_j
    localparam int CROSS_W   = PROD_B_W - 1;       // |v x a| magnitude
    localparam int BQ_W      = ROOT_W + 2;         // |b_i| < 4 * root

    typedef logic signed [DATA_W-1:0]   comp_t;
    typedef logic signed [DATA_W:0]     wcomp_t;
    typedef logic        [LEN_W-1:0]    len_t;
    typedef logic signed [A_W-1:0]      acomp_t;
    typedef logic signed [PROD_B_W-1:0] prod_t;

    typedef enum logic [1:0] {
        PICK_X,
        PICK_Y,
        PICK_Z
    } pick_t;

    typedef struct packed {
        comp_t vec_x;
        comp_t vec_y;
        comp_t vec_z;
    } vec_req_t;

    typedef struct packed {
        comp_t perp_a_x;
        comp_t perp_a_y;
        comp_t perp_a_z;
        comp_t perp_b_x;
        comp_t perp_b_y;
        comp_t perp_b_z;
        logic  degenerate;
    } perp_rsp_t;

    typedef struct packed {
        logic deg;      // length below threshold
        logic zero;     // zero length, result forced to zero
    } flags_t;

    typedef struct packed {
        comp_t  [2:0] v;
        wcomp_t [2:0] w;
    } geo_t;

    typedef struct packed {
        comp_t  [2:0] v;
        wcomp_t [2:0] w;
        len_t         len;
        len_t         wlen;
    } lens_t;

    typedef struct packed {
        comp_t  [2:0] v;
        len_t         len;
        logic   [2:0] neg;
        flags_t       flags;
    } astage_t;

    typedef struct packed {
        acomp_t [2:0] a;
        logic   [2:0] neg;
        flags_t       flags;
    } bstage_t;

endpackage

`default_nettype wire

### design/pfv_delay.sv
// ----------------------------------------------------------------------------
// pfv_delay
// side-data delay line with valid bits, advances on enable
// ----------------------------------------------------------------------------
`default_nettype none

module pfv_delay #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              vld_i,
    input  wire logic [DATA_W-1:0] data_i,
    output logic                   vld_o,
    output logic      [DATA_W-1:0] data_o
);

    logic [DEPTH-1:0]  vld_reg;
    logic [DATA_W-1:0] data_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], vld_i};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= data_i;
            for (int i = 1; i < DEPTH; i++)
            begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign vld_o  = vld_reg[DEPTH-1];
    assign data_o = data_reg[DEPTH-1];

endmodule

`default_nettype wire

### design/pfv_sqrt.sv
// ----------------------------------------------------------------------------
// pfv_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module pfv_sqrt #(
    parameter int IN_W = 64
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [IN_W-1:0]   radicand,
    output logic      [IN_W/2-1:0] root
);

    localparam int RW    = IN_W / 2;
    localparam int REM_W = RW + 2;

    logic [REM_W-1:0] rem_reg  [RW];
    logic [RW-1:0]    root_reg [RW];
    logic [IN_W-1:0]  rad_reg  [RW];

    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [RW-1:0]    root_in;
        logic [IN_W-1:0]  rad_in;
        logic [REM_W+1:0] work;
        logic [REM_W+1:0] trial;
        logic             fits;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        // bring down two radicand bits, try root*4+1
        assign work  = {rem_in, rad_in[IN_W-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign fits  = (work >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= fits ? REM_W'(work - trial) : REM_W'(work);
                root_reg[s] <= {root_in[RW-2:0], fits};
                rad_reg[s]  <= {rad_in[IN_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

`default_nettype wire

### design/pfv_div.sv
// ----------------------------------------------------------------------------
// pfv_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module pfv_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 32,
    parameter int QUO_W = 24
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,   // num < den * 2**QUO_W
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] low_reg [QUO_W];   // dividend bits out, quotient bits in
    logic [DEN_W-1:0] den_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] low_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   work;
        logic             fits;

        if (s == 0)
        begin : g_first
            assign rem_in = DEN_W'(num[NUM_W-1:QUO_W]);
            assign low_in = num[QUO_W-1:0];
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign low_in = low_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        assign work = {rem_in, low_in[QUO_W-1]};
        assign fits = (work >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= fits ? DEN_W'(work - {1'b0, den_in}) : DEN_W'(work);
                low_reg[s] <= {low_in[QUO_W-2:0], fits};
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = low_reg[QUO_W-1];

endmodule

`default_nettype wire

### design/perpendicular_pair_from_vector.sv
// ----------------------------------------------------------------------------
// perpendicular_pair_from_vector
// builds two vectors a, b with a x b along v and lengths sqrt(|v|)
// ----------------------------------------------------------------------------
// usage
//   in_req (vec_x, vec_y, vec_z, signed Q16.16) is taken when in_valid and
//   in_ready are both high; out_rsp (a, b, degenerate) leaves when out_valid
//   and out_ready are both high. one result per request, in order.
//   cfg_we writes cfg_wdata into min_length on the same edge; write it only
//   while no request is in flight.
// throughput and depth
//   one request per cycle unless the receiver stalls the output. the
//   pipeline depth is set by the bit-serial stages: 32 for |v| and |w|, 24 for
//   sqrt(|v|), 24 for a = w*root/|w| and 26 for b = (v x a)/|v|.
// reset
//   all valid bits clear, min_length returns to 1; pipeline starts empty.
// receiver stall
//   while out_valid is high and out_ready low the whole pipeline freezes
//   and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module perpendicular_pair_from_vector (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire pfv_pkg::vec_req_t         in_req,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output pfv_pkg::perp_rsp_t             out_rsp,
    input  wire logic                      cfg_we,
    input  wire logic [pfv_pkg::CFG_W-1:0] cfg_wdata
);

    import pfv_pkg::*;

    // global advance: every stage moves unless the output is held
    logic adv;
    logic out_valid_reg;
    perp_rsp_t out_rsp_reg;
    logic [CFG_W-1:0] min_len_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            min_len_reg <= cfg_wdata;
        end
    end

    // ---- stage a: capture request ----
    logic         a_vld_reg;
    comp_t  [2:0] a_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_v_reg[0] <= in_req.vec_x;
            a_v_reg[1] <= in_req.vec_y;
            a_v_reg[2] <= in_req.vec_z;
        end
    end

    // ---- stage b: smallest component, perpendicular w ----
    logic [2:0][DATA_W-1:0] mag;
    pick_t                  pick_next;
    wcomp_t [2:0]           w_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            // unsigned negate keeps 2**31 exact
            mag[k] = a_v_reg[k][DATA_W-1] ? (~a_v_reg[k] + 1'b1) : a_v_reg[k];
        end
        // lowest index wins ties
        pick_next = PICK_X;
        if (mag[1] < mag[0])
        begin
            pick_next = PICK_Y;
        end
        if (mag[2] < ((pick_next == PICK_Y) ? mag[1] : mag[0]))
        begin
            pick_next = PICK_Z;
        end
        case (pick_next)
            PICK_X:
            begin
                w_next[0] = '0;
                w_next[1] = wcomp_t'($signed(a_v_reg[2]));
                w_next[2] = -wcomp_t'($signed(a_v_reg[1]));
            end
            PICK_Y:
            begin
                w_next[0] = wcomp_t'($signed(a_v_reg[2]));
                w_next[1] = '0;
                w_next[2] = -wcomp_t'($signed(a_v_reg[0]));
            end
            default:
            begin
                w_next[0] = -wcomp_t'($signed(a_v_reg[1]));
                w_next[1] = wcomp_t'($signed(a_v_reg[0]));
                w_next[2] = '0;
            end
        endcase
    end

    logic         b_vld_reg;
    comp_t  [2:0] b_v_reg;
    wcomp_t [2:0] b_w_reg;
    pick_t        b_pick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_v_reg    <= a_v_reg;
            b_w_reg    <= w_next;
            b_pick_reg <= pick_next;
        end
    end

    // ---- stage c: squares ----
    logic                 c_vld_reg;
    comp_t  [2:0]         c_v_reg;
    wcomp_t [2:0]         c_w_reg;
    pick_t                c_pick_reg;
    logic [2:0][SQ_W-1:0] c_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_v_reg    <= b_v_reg;
            c_w_reg    <= b_w_reg;
            c_pick_reg <= b_pick_reg;
            for (int k = 0; k < 3; k++)
            begin
                c_sq_reg[k] <= SQ_W'($signed(b_v_reg[k]) * $signed(b_v_reg[k]));
            end
        end
    end

    // ---- stage d: |v|^2 and |w|^2 ----
    logic [SQ_W-1:0] wsq_next;

    always_comb
    begin
        case (c_pick_reg)
            PICK_X:  wsq_next = c_sq_reg[1] + c_sq_reg[2];
            PICK_Y:  wsq_next = c_sq_reg[0] + c_sq_reg[2];
            PICK_Z:  wsq_next = c_sq_reg[0] + c_sq_reg[1];
            default: wsq_next = c_sq_reg[1] + c_sq_reg[2];
        endcase
    end

    logic            d_vld_reg;
    geo_t            d_geo_reg;
    logic [SQ_W-1:0] d_s_reg;
    logic [SQ_W-1:0] d_wsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_geo_reg.v <= c_v_reg;
            d_geo_reg.w <= c_w_reg;
            d_s_reg     <= c_sq_reg[0] + c_sq_reg[1] + c_sq_reg[2];
            d_wsq_reg   <= wsq_next;
        end
    end

    // ---- |v| and |w| square roots ----
    len_t len;
    len_t wlen;
    logic e_vld;
    geo_t e_geo;

    pfv_sqrt #(.IN_W(SQ_W)) u_sqrt_len (
        .clk      (clk),
        .en       (adv),
        .radicand (d_s_reg),
        .root     (len)
    );

    pfv_sqrt #(.IN_W(SQ_W)) u_sqrt_wlen (
        .clk      (clk),
        .en       (adv),
        .radicand (d_wsq_reg),
        .root     (wlen)
    );

    pfv_delay #(.DATA_W($bits(geo_t)), .DEPTH(LEN_W)) u_dly_geo (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .vld_i  (d_vld_reg),
        .data_i (d_geo_reg),
        .vld_o  (e_vld),
        .data_o (e_geo)
    );

    // ---- sqrt(|v|) ----
    lens_t             e_lens;
    logic [ROOT_W-1:0] root;
    logic              r_vld;
    lens_t             r_lens;

    always_comb
    begin
        e_lens.v    = e_geo.v;
        e_lens.w    = e_geo.w;
        e_lens.len  = len;
        e_lens.wlen = wlen;
    end

    pfv_sqrt #(.IN_W(ROOT_IN_W)) u_sqrt_root (
        .clk      (clk),
        .en       (adv),
        .radicand ({len, {FRAC_W{1'b0}}}),
        .root     (root)
    );

    pfv_delay #(.DATA_W($bits(lens_t)), .DEPTH(ROOT_W)) u_dly_lens (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .vld_i  (e_vld),
        .data_i (e_lens),
        .vld_o  (r_vld),
        .data_o (r_lens)
    );

    // ---- stage f: |w_i| * root, sign and flags ----
    logic [2:0][DATA_W-1:0] wmag;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            wmag[k] = r_lens.w[k][DATA_W] ? DATA_W'(-$signed(r_lens.w[k]))
                                          : DATA_W'($signed(r_lens.w[k]));
        end
    end

    logic                     f_vld_reg;
    logic [2:0][PROD_A_W-1:0] f_num_reg;
    len_t                     f_wlen_reg;
    astage_t                  f_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_vld_reg <= r_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                f_num_reg[k]      <= PROD_A_W'(wmag[k]) * PROD_A_W'(root);
                f_side_reg.neg[k] <= r_lens.w[k][DATA_W];
            end
            f_wlen_reg            <= r_lens.wlen;
            f_side_reg.v          <= r_lens.v;
            f_side_reg.len        <= r_lens.len;
            f_side_reg.flags.deg  <= (r_lens.len < LEN_W'(min_len_reg));
            f_side_reg.flags.zero <= (r_lens.len == '0) || (r_lens.wlen == '0);
        end
    end

    // ---- a = w * root / |w| ----
    logic [2:0][ROOT_W-1:0] aq;
    logic                   q_vld;
    astage_t                q_side;

    for (genvar k = 0; k < 3; k++)
    begin : g_div_a
        pfv_div #(.NUM_W(PROD_A_W), .DEN_W(LEN_W), .QUO_W(ROOT_W)) u_div_a (
            .clk (clk),
            .en  (adv),
            .num (f_num_reg[k]),
            .den (f_wlen_reg),
            .quo (aq[k])
        );
    end

    pfv_delay #(.DATA_W($bits(astage_t)), .DEPTH(ROOT_W)) u_dly_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .vld_i  (f_vld_reg),
        .data_i (f_side_reg),
        .vld_o  (q_vld),
        .data_o (q_side)
    );

    // ---- stage g: signed a ----
    logic         g_vld_reg;
    acomp_t [2:0] g_a_reg;
    comp_t  [2:0] g_v_reg;
    len_t         g_len_reg;
    flags_t       g_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            g_vld_reg <= q_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                g_a_reg[k] <= q_side.neg[k] ? -$signed({1'b0, aq[k]})
                                            : $signed({1'b0, aq[k]});
            end
            g_v_reg     <= q_side.v;
            g_len_reg   <= q_side.len;
            g_flags_reg <= q_side.flags;
        end
    end

    // ---- stage h: cross product terms ----
    logic              h_vld_reg;
    prod_t [2:0][1:0]  h_p_reg;
    acomp_t [2:0]      h_a_reg;
    len_t              h_len_reg;
    flags_t            h_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            h_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_p_reg[0][0] <= $signed(g_v_reg[1]) * $signed(g_a_reg[2]);
            h_p_reg[0][1] <= $signed(g_v_reg[2]) * $signed(g_a_reg[1]);
            h_p_reg[1][0] <= $signed(g_v_reg[2]) * $signed(g_a_reg[0]);
            h_p_reg[1][1] <= $signed(g_v_reg[0]) * $signed(g_a_reg[2]);
            h_p_reg[2][0] <= $signed(g_v_reg[0]) * $signed(g_a_reg[1]);
            h_p_reg[2][1] <= $signed(g_v_reg[1]) * $signed(g_a_reg[0]);
            h_a_reg       <= g_a_reg;
            h_len_reg     <= g_len_reg;
            h_flags_reg   <= g_flags_reg;
        end
    end

    // ---- stage i: v x a, split into sign and magnitude ----
    logic signed [2:0][PROD_B_W:0] diff;
    logic        [2:0][PROD_B_W:0] dmag;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k] = $signed(h_p_reg[k][0]) - $signed(h_p_reg[k][1]);
            dmag[k] = diff[k][PROD_B_W] ? -$signed(diff[k]) : $signed(diff[k]);
        end
    end

    logic                    i_vld_reg;
    logic [2:0][CROSS_W-1:0] i_num_reg;
    len_t                    i_len_reg;
    bstage_t                 i_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            i_vld_reg <= h_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                // |v x a| < 2**CROSS_W
                i_num_reg[k]      <= dmag[k][CROSS_W-1:0];
                i_side_reg.neg[k] <= diff[k][PROD_B_W];
            end
            i_len_reg        <= h_len_reg;
            i_side_reg.a     <= h_a_reg;
            i_side_reg.flags <= h_flags_reg;
        end
    end

    // ---- b = (v x a) / |v| ----
    logic [2:0][BQ_W-1:0] bq;
    logic                 o_vld;
    bstage_t              o_side;

    for (genvar k = 0; k < 3; k++)
    begin : g_div_b
        pfv_div #(.NUM_W(CROSS_W), .DEN_W(LEN_W), .QUO_W(BQ_W)) u_div_b (
            .clk (clk),
            .en  (adv),
            .num (i_num_reg[k]),
            .den (i_len_reg),
            .quo (bq[k])
        );
    end

    pfv_delay #(.DATA_W($bits(bstage_t)), .DEPTH(BQ_W)) u_dly_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .vld_i  (i_vld_reg),
        .data_i (i_side_reg),
        .vld_o  (o_vld),
        .data_o (o_side)
    );

    // ---- output register ----
    logic signed [2:0][BQ_W:0] bval;
    perp_rsp_t                 rsp_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            bval[k] = o_side.neg[k] ? -$signed({1'b0, bq[k]}) : $signed({1'b0, bq[k]});
        end
        // a and b never reach the Q16.16 limits, sign extension suffices
        rsp_next.perp_a_x   = DATA_W'($signed(o_side.a[0]));
        rsp_next.perp_a_y   = DATA_W'($signed(o_side.a[1]));
        rsp_next.perp_a_z   = DATA_W'($signed(o_side.a[2]));
        rsp_next.perp_b_x   = DATA_W'($signed(bval[0]));
        rsp_next.perp_b_y   = DATA_W'($signed(bval[1]));
        rsp_next.perp_b_z   = DATA_W'($signed(bval[2]));
        rsp_next.degenerate = o_side.flags.deg;
        // short or zero vector: all components zero
        if (o_side.flags.deg || o_side.flags.zero)
        begin
            rsp_next.perp_a_x = '0;
            rsp_next.perp_a_y = '0;
            rsp_next.perp_a_z = '0;
            rsp_next.perp_b_x = '0;
            rsp_next.perp_b_y = '0;
            rsp_next.perp_b_z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= o_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_rsp_reg <= rsp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    // ---- assertions ----
    `PFV_ASSERT(a_deg_zero, out_valid && out_rsp.degenerate |-> out_rsp.perp_a_x == '0 && out_rsp.perp_b_z == '0)
    `PFV_ASSERT(a_range_a, out_valid |-> out_rsp.perp_a_y[31:24] == 8'h00 || out_rsp.perp_a_y[31:24] == 8'hFF)
    `PFV_ASSERT(a_range_b, out_valid |-> out_rsp.perp_b_x[31:26] == 6'h00 || out_rsp.perp_b_x[31:26] == 6'h3F)
    `PFV_ASSERT(a_cfg_write, cfg_we |=> min_len_reg == $past(cfg_wdata))

endmodule

`default_nettype wire
